@@ design/kls_pkg.sv @@
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants for the lattice swap step
// Field widths, item/result structs, control codes, the FSM state type and a reciprocal table.
// ----------------------------------------------------------------------------
package kls_pkg;

	localparam int KIND_W     = 2;
	localparam int COORD_W    = 7;
	localparam int DRAW_W     = 24;
	localparam int CLR_W      = 5;
	localparam int WORD_W     = 24;
	localparam int BETA_W     = 24;
	localparam int STATUS_W   = 3;
	localparam int CHANGE_W   = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	// exponential datapath
	localparam int Q_W    = 31;   // Q.30 values up to and including 1.0
	localparam int SUM_W  = 34;
	localparam int PROD_W = BETA_W + CHANGE_W - 1;
	localparam int TERMS  = 16;
	localparam logic [Q_W-1:0] ONE30 = Q_W'(1) << 30;

	localparam logic [KIND_W-1:0] KIND_SWAP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WCPL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WSITE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BETA = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG = 4'd1;

	localparam logic [STATUS_W-1:0] STAT_ACCEPT   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_SAME     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_ADJACENT = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_WRITE    = 3'd4;

	localparam logic [BETA_W-1:0] BETA_RESET = 24'd65536;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [COORD_W-1:0]        first_row;
		logic [COORD_W-1:0]        first_col;
		logic [COORD_W-1:0]        second_row;
		logic [COORD_W-1:0]        second_col;
		logic [DRAW_W-1:0]         uniform_draw;
		logic [CLR_W-1:0]          color_first;
		logic [CLR_W-1:0]          color_second;
		logic signed [WORD_W-1:0]  coupling_word;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic signed [CHANGE_W-1:0] energy_delta;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_WRAP,
		S_DISPATCH,
		S_RD1,
		S_RD2,
		S_CHECK,
		S_NB_ADDR,
		S_NB_T1,
		S_NB_T2,
		S_NB_T3,
		S_DELTA,
		S_MULT,
		S_SER_INIT,
		S_EXP_MUL,
		S_EXP_REC,
		S_EXP_FIX,
		S_CLAMP,
		S_POW,
		S_CMP,
		S_WB1,
		S_WB2,
		S_RESP
	} state_t;

	// floor(2^31 / k) for k = 1..16; term / k = this * term >> 31, plus one fix step
	function automatic logic [31:0] recip(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd1:    r = 32'd2147483648;
			5'd2:    r = 32'd1073741824;
			5'd3:    r = 32'd715827882;
			5'd4:    r = 32'd536870912;
			5'd5:    r = 32'd429496729;
			5'd6:    r = 32'd357913941;
			5'd7:    r = 32'd306783378;
			5'd8:    r = 32'd268435456;
			5'd9:    r = 32'd238609294;
			5'd10:   r = 32'd214748364;
			5'd11:   r = 32'd195225786;
			5'd12:   r = 32'd178956970;
			5'd13:   r = 32'd165191049;
			5'd14:   r = 32'd153391689;
			5'd15:   r = 32'd143165576;
			5'd16:   r = 32'd134217728;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/kls_item_if.sv @@
// ----------------------------------------------------------------------------
// kls_item_if: input item channel
// valid/ready channel carrying one work item per beat.
// ----------------------------------------------------------------------------
interface kls_item_if import kls_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/kls_result_if.sv @@
// ----------------------------------------------------------------------------
// kls_result_if: result channel
// valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface kls_result_if import kls_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/kls_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kls_cfg_if: configuration write channel
// valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface kls_cfg_if import kls_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/kawasaki_lattice_swap_step.sv @@
// ----------------------------------------------------------------------------
// kawasaki_lattice_swap_step: Kawasaki exchange with Metropolis acceptance
// Lattice and coupling table in single-port synchronous RAMs, one sequencer.
// ----------------------------------------------------------------------------
// One item is worked at a time, and the rate is set by the single port of each
// RAM and by the exponential, whose multiplies run one after another. Every
// item first folds its coordinates by subtracting SIDE one step at a time;
// write items then write and respond. A swap attempt reads both sites, then
// per neighbor does one lattice read and two table reads, over four neighbors
// per site, or eight in diagonal mode. A positive delta then runs the Q.30 exp
// series over 16 terms, each in a multiply, reciprocal and fix step, a second
// pass for e^-1 when beta*delta is one or more, and one multiply per unit of
// its integer part (at most 31). A same-color or adjacent swap skips the
// neighbor and exp steps. A new item is taken while the previous result still
// waits in the output register. Both RAMs come up undefined and are not cleared.
// ----------------------------------------------------------------------------
module kawasaki_lattice_swap_step import kls_pkg::*; #(
	parameter int SIDE   = 128,
	parameter int COLORS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	kls_item_if.sink   item,
	kls_result_if.source result,
	kls_cfg_if.sink    cfg
);

	localparam int NCOL = COLORS + 1;
	localparam int CW   = $clog2(SIDE);
	localparam int KW   = (CW > COORD_W) ? CW : COORD_W;
	localparam int AW   = $clog2(SIDE * SIDE);
	localparam int TAW  = $clog2(NCOL * NCOL);

	// ---------------- configuration ----------------
	logic [BETA_W-1:0] beta_q;
	logic              diag_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RESET;
			diag_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_BETA)
				beta_q <= cfg.data[BETA_W-1:0];
			else if (cfg.index == REG_DIAG)
				diag_q <= cfg.data[0];
		end
	end

	// ---------------- memories ----------------
	logic [CLR_W-1:0]         lat_mem [SIDE*SIDE];
	logic [WORD_W-1:0]        tab_mem [NCOL*NCOL];
	logic                     lat_we, tab_we;
	logic [AW-1:0]            lat_addr;
	logic [TAW-1:0]           tab_addr;
	logic [CLR_W-1:0]         lat_wdata, lat_rdata;
	logic [WORD_W-1:0]        tab_wdata;
	logic signed [WORD_W-1:0] tab_rdata;

	always_ff @(posedge clk) begin
		if (lat_we)
			lat_mem[lat_addr] <= lat_wdata;
		lat_rdata <= lat_mem[lat_addr];
	end

	always_ff @(posedge clk) begin
		if (tab_we)
			tab_mem[tab_addr] <= tab_wdata;
		tab_rdata <= tab_mem[tab_addr];
	end

	// ---------------- coordinate helpers ----------------
	function automatic logic [KW-1:0] inc_w(input logic [KW-1:0] v);
		return (int'(v) == SIDE - 1) ? '0 : KW'(int'(v) + 1);
	endfunction

	function automatic logic [KW-1:0] dec_w(input logic [KW-1:0] v);
		return (v == '0) ? KW'(SIDE - 1) : KW'(int'(v) - 1);
	endfunction

	function automatic logic [AW-1:0] site_addr(input logic [KW-1:0] r, input logic [KW-1:0] c);
		return AW'(int'(r) * SIDE + int'(c));
	endfunction

	function automatic logic [TAW-1:0] pair_addr(input logic [CLR_W-1:0] a,
		input logic [CLR_W-1:0] b);
		return TAW'(int'(a) * NCOL + int'(b));
	endfunction

	// ---------------- item registers ----------------
	state_t state_q, state_d;

	logic [KIND_W-1:0]        kind_q;
	logic [KW-1:0]            r1_q, c1_q, r2_q, c2_q;
	logic [DRAW_W-1:0]        draw_q;
	logic [CLR_W-1:0]         ca_q, cb_q;
	logic [WORD_W-1:0]        word_q;
	logic [CLR_W-1:0]         s1_q, s2_q;
	logic [3:0]               nb_q;      // [3] picks the site, [2:0] the neighbor
	logic [CLR_W-1:0]         ncol_q;
	logic signed [CHANGE_W-1:0] acc_q, d_q;
	logic [PROD_W-1:0]        prod_q;
	logic [Q_W-1:0]           f_q, term_q, x_q, y_q, r_q, e1_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [4:0]               k_q, n_q;
	logic                     pass_q;
	logic [STATUS_W-1:0]      stat_q;
	logic                     res_valid_q;
	result_t                  res_q;

	logic item_acc;
	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;

	// ---------------- combinational helpers ----------------
	logic wrapped, adjacent, last_nb, whole_big, out_free, draw_ok;
	logic [KW-1:0] nb_r, nb_c, base_r, base_c;
	logic [CLR_W-1:0] own_c, other_c;
	logic signed [CHANGE_W-1:0] d_comb;
	logic [Q_W-1:0] q_fix, clamped;
	logic [Q_W-1:0] rem_fix;

	assign wrapped = (int'(r1_q) < SIDE) && (int'(c1_q) < SIDE)
		&& (int'(r2_q) < SIDE) && (int'(c2_q) < SIDE);

	assign adjacent = ((c1_q == c2_q) && ((r1_q == inc_w(r2_q)) || (r1_q == dec_w(r2_q))))
		|| ((r1_q == r2_q) && ((c1_q == inc_w(c2_q)) || (c1_q == dec_w(c2_q))));

	assign last_nb  = diag_q ? (nb_q[2:0] == 3'd7) : (nb_q[2:0] == 3'd3);
	assign base_r   = nb_q[3] ? r2_q : r1_q;
	assign base_c   = nb_q[3] ? c2_q : c1_q;
	assign own_c    = nb_q[3] ? s2_q : s1_q;
	assign other_c  = nb_q[3] ? s1_q : s2_q;

	always_comb begin
		nb_r = base_r;
		nb_c = base_c;
		case (nb_q[2:0])
			3'd0: nb_c = dec_w(base_c);
			3'd1: nb_c = inc_w(base_c);
			3'd2: nb_r = dec_w(base_r);
			3'd3: nb_r = inc_w(base_r);
			3'd4: begin nb_r = dec_w(base_r); nb_c = dec_w(base_c); end
			3'd5: begin nb_r = inc_w(base_r); nb_c = inc_w(base_c); end
			3'd6: begin nb_r = dec_w(base_r); nb_c = inc_w(base_c); end
			default: begin nb_r = inc_w(base_r); nb_c = dec_w(base_c); end
		endcase
	end

	// floor halving in diagonal mode
	assign d_comb    = diag_q ? (acc_q >>> 1) : acc_q;
	assign whole_big = |prod_q[PROD_W-1:37];

	// term / k correction: quotient estimate is low by at most one
	assign rem_fix = x_q - Q_W'(y_q * Q_W'(k_q));
	assign q_fix   = (rem_fix >= Q_W'(k_q)) ? (y_q + Q_W'(1)) : y_q;

	assign clamped = (sum_q < 0) ? '0
		: (sum_q > SUM_W'(ONE30)) ? ONE30 : sum_q[Q_W-1:0];

	assign draw_ok  = ({1'b0, draw_q} <= r_q[Q_W-1:6]);
	assign out_free = !res_valid_q || result.ready;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (item_acc) state_d = S_WRAP;
			S_WRAP:     if (wrapped) state_d = S_DISPATCH;
			S_DISPATCH: state_d = (kind_q == KIND_SWAP) ? S_RD1 : S_RESP;
			S_RD1:      state_d = S_RD2;
			S_RD2:      state_d = S_CHECK;
			S_CHECK: begin
				if (lat_rdata == s1_q || adjacent)
					state_d = S_RESP;
				else
					state_d = S_NB_ADDR;
			end
			S_NB_ADDR:  state_d = S_NB_T1;
			S_NB_T1:    state_d = S_NB_T2;
			S_NB_T2:    state_d = S_NB_T3;
			S_NB_T3:    state_d = (last_nb && nb_q[3]) ? S_DELTA : S_NB_ADDR;
			S_DELTA:    state_d = (d_comb <= 0) ? S_WB1 : S_MULT;
			S_MULT:     state_d = S_SER_INIT;
			S_SER_INIT: state_d = whole_big ? S_CMP : S_EXP_MUL;
			S_EXP_MUL:  state_d = S_EXP_REC;
			S_EXP_REC:  state_d = S_EXP_FIX;
			S_EXP_FIX:  state_d = (k_q == 5'(TERMS)) ? S_CLAMP : S_EXP_MUL;
			S_CLAMP: begin
				if (pass_q)
					state_d = S_POW;
				else if (prod_q[36:32] == 5'd0)
					state_d = S_CMP;
				else
					state_d = S_EXP_MUL;
			end
			S_POW:      if (n_q == 5'd0) state_d = S_CMP;
			S_CMP:      state_d = draw_ok ? S_WB1 : S_RESP;
			S_WB1:      state_d = S_WB2;
			S_WB2:      state_d = S_RESP;
			S_RESP:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// ---------------- memory controls ----------------
	always_comb begin
		lat_we    = 1'b0;
		lat_addr  = site_addr(r1_q, c1_q);
		lat_wdata = s2_q;
		tab_we    = 1'b0;
		tab_addr  = pair_addr(ca_q, cb_q);
		tab_wdata = word_q;
		unique case (state_q)
			S_DISPATCH: begin
				if (kind_q == KIND_WCPL)
					tab_we = (int'(ca_q) <= COLORS) && (int'(cb_q) <= COLORS);
				if (kind_q == KIND_WSITE) begin
					lat_we    = (int'(ca_q) <= COLORS);
					lat_wdata = ca_q;
				end
			end
			S_RD2:     lat_addr = site_addr(r2_q, c2_q);
			S_NB_ADDR: lat_addr = site_addr(nb_r, nb_c);
			S_NB_T1:   tab_addr = pair_addr(own_c, lat_rdata);
			S_NB_T2:   tab_addr = pair_addr(other_c, ncol_q);
			S_WB1:     lat_we = 1'b1;
			S_WB2: begin
				lat_we    = 1'b1;
				lat_addr  = site_addr(r2_q, c2_q);
				lat_wdata = s1_q;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					kind_q <= item.data.kind;
					r1_q   <= KW'(item.data.first_row);
					c1_q   <= KW'(item.data.first_col);
					r2_q   <= KW'(item.data.second_row);
					c2_q   <= KW'(item.data.second_col);
					draw_q <= item.data.uniform_draw;
					ca_q   <= item.data.color_first;
					cb_q   <= item.data.color_second;
					word_q <= item.data.coupling_word;
					stat_q <= STAT_WRITE;
					d_q    <= '0;
				end
			end
			S_WRAP: begin
				// fold coordinates below SIDE one subtraction at a time
				if (int'(r1_q) >= SIDE) r1_q <= KW'(int'(r1_q) - SIDE);
				if (int'(c1_q) >= SIDE) c1_q <= KW'(int'(c1_q) - SIDE);
				if (int'(r2_q) >= SIDE) r2_q <= KW'(int'(r2_q) - SIDE);
				if (int'(c2_q) >= SIDE) c2_q <= KW'(int'(c2_q) - SIDE);
			end
			S_CHECK: begin
				nb_q  <= '0;
				acc_q <= '0;
				if (lat_rdata == s1_q)
					stat_q <= STAT_SAME;
				else if (adjacent)
					stat_q <= STAT_ADJACENT;
			end
			S_RD2:   s1_q <= lat_rdata;
			S_NB_T1: ncol_q <= lat_rdata;
			S_NB_T2: acc_q <= acc_q + CHANGE_W'(tab_rdata);
			S_NB_T3: begin
				acc_q <= acc_q - CHANGE_W'(tab_rdata);
				nb_q  <= last_nb ? 4'd8 : nb_q + 4'd1;
			end
			S_DELTA: begin
				d_q    <= d_comb;
				stat_q <= STAT_ACCEPT;
			end
			S_MULT:  prod_q <= PROD_W'(beta_q) * PROD_W'(d_q[CHANGE_W-2:0]);
			S_SER_INIT: begin
				f_q    <= Q_W'(prod_q[31:2]);
				term_q <= ONE30;
				sum_q  <= SUM_W'(ONE30);
				k_q    <= 5'd1;
				pass_q <= 1'b0;
				n_q    <= prod_q[36:32];
				r_q    <= '0;
			end
			S_EXP_MUL: x_q <= Q_W'((62'(term_q) * 62'(f_q)) >> 30);
			S_EXP_REC: y_q <= Q_W'((63'(x_q) * 63'(recip(k_q))) >> 31);
			S_EXP_FIX: begin
				term_q <= q_fix;
				sum_q  <= k_q[0] ? (sum_q - SUM_W'(q_fix)) : (sum_q + SUM_W'(q_fix));
				k_q    <= k_q + 5'd1;
			end
			S_CLAMP: begin
				if (pass_q) begin
					e1_q <= clamped;
				end else begin
					r_q    <= clamped;
					f_q    <= ONE30;
					term_q <= ONE30;
					sum_q  <= SUM_W'(ONE30);
					k_q    <= 5'd1;
					pass_q <= 1'b1;
				end
			end
			S_POW: begin
				if (n_q != 5'd0) begin
					r_q <= Q_W'((62'(r_q) * 62'(e1_q)) >> 30);
					n_q <= n_q - 5'd1;
				end
			end
			S_CMP: begin
				if (!draw_ok) begin
					stat_q <= STAT_REJECT;
					d_q    <= '0;
				end
			end
			default: ;
		endcase
		// the RD2 arm above latches site one; CHECK then sees site two on the port
		if (state_q == S_CHECK)
			s2_q <= lat_rdata;
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			res_q.status       <= stat_q;
			res_q.energy_delta <= d_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
